// ===== hw/rtl/mapcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path conflict finder package
// Shared field widths, command and result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mapcf_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned RobotW    = 3;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned TimeW     = 8;
  localparam int unsigned CostW     = 12;
  localparam int unsigned LongW     = 9;
  localparam int unsigned RobotsCfgW = 4;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [RobotsCfgW-1:0] RobotsReset = 4'd2;

  // Register index, taken from paddr[2].
  localparam logic RegRobots = 1'b0;
  localparam logic RegCost   = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdFind   = 2'd2
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KindNone   = 2'd0,
    KindVertex = 2'd1,
    KindEdge   = 2'd2,
    KindEmpty  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StCheck,
    StLoad,
    StDrain,
    StAdv,
    StVertex,
    StEdge
  } state_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic scan;
    logic idx_clr;
    logic ld;
    logic adv;
    logic vtx;
    logic edge_chk;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic err;
    logic mk_zero;
    logic init;
    logic vtx_hit;
    logic edge_hit;
    logic t_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/mapcf_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path conflict finder channels
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface mapcf_in_if;
  import mapcf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [RobotW-1:0] robot;
  logic [CoordW-1:0] cell_x;
  logic [CoordW-1:0] cell_y;

  modport source (output valid, cmd, robot, cell_x, cell_y, input ready);
  modport sink (input valid, cmd, robot, cell_x, cell_y, output ready);
endinterface

interface mapcf_out_if;
  import mapcf_pkg::*;
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  conflict_kind;
  logic [RobotW-1:0] first_robot;
  logic [RobotW-1:0] second_robot;
  logic [TimeW-1:0]  conflict_time;
  logic [CoordW-1:0] from_x;
  logic [CoordW-1:0] from_y;
  logic [CoordW-1:0] to_x;
  logic [CoordW-1:0] to_y;
  logic [CostW-1:0]  cost_value;
  logic [LongW-1:0]  longest_path;
  logic [CostW-1:0]  total_length;
  logic              overflowed;

  modport source (output valid, conflict_kind, first_robot, second_robot, conflict_time,
                  from_x, from_y, to_x, to_y, cost_value, longest_path, total_length,
                  overflowed, input ready);
  modport sink (input valid, conflict_kind, first_robot, second_robot, conflict_time,
                from_x, from_y, to_x, to_y, cost_value, longest_path, total_length,
                overflowed, output ready);
endinterface

// ===== hw/rtl/multi_agent_path_conflict_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-robot path conflict finder
// Stores one grid path per robot and reports the first vertex or edge-swap
// conflict on a find transaction, together with path cost figures.
// ----------------------------------------------------------------------------
// Clear and append transactions can arrive back to back while no result is waiting
// to be taken. A find reads the path memory through its single read port, one cell
// per cycle, and checks each robot against the later ones, for n robots and makespan
// T; a conflict, an empty path or a zero makespan ends it early.
// No transaction is taken until the result is taken.
// Reset empties all paths and the overflow flag; no memory clearing pass is run.
module multi_agent_path_conflict_finder #(
  parameter int unsigned MAX_ROBOTS = 8,
  parameter int unsigned MAX_PATH   = 256,
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mapcf_in_if.sink                          in_i,
  mapcf_out_if.source                       out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mapcf_pkg::ApbAddrW-1:0]    paddr,
  input  logic [mapcf_pkg::ApbDataW-1:0]    pwdata,
  output logic [mapcf_pkg::ApbDataW-1:0]    prdata,
  output logic                              pready
);
  import mapcf_pkg::*;

  logic [RobotsCfgW-1:0] robots_q;
  logic                  cost_kind_q;
  logic                  cfg_wr;
  dp_cmd_t               dp_cmd;
  dp_sts_t               dp_sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robots_q    <= RobotsReset;
      cost_kind_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegRobots: robots_q    <= pwdata[RobotsCfgW-1:0];
        RegCost:   cost_kind_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == RegCost) ? ApbDataW'(cost_kind_q) : ApbDataW'(robots_q);

  mapcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  mapcf_dp #(
    .MAX_ROBOTS (MAX_ROBOTS),
    .MAX_PATH   (MAX_PATH),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .robots_in_use_i (robots_q),
    .cost_kind_i     (cost_kind_q),
    .robot_i         (in_i.robot),
    .cell_x_i        (in_i.cell_x),
    .cell_y_i        (in_i.cell_y),
    .conflict_kind_o (out_o.conflict_kind),
    .first_robot_o   (out_o.first_robot),
    .second_robot_o  (out_o.second_robot),
    .conflict_time_o (out_o.conflict_time),
    .from_x_o        (out_o.from_x),
    .from_y_o        (out_o.from_y),
    .to_x_o          (out_o.to_x),
    .to_y_o          (out_o.to_y),
    .cost_value_o    (out_o.cost_value),
    .longest_path_o  (out_o.longest_path),
    .total_length_o  (out_o.total_length),
    .overflowed_o    (out_o.overflowed)
  );

  // A finished find always raises the result valid in the next cycle.
  a_fin_to_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.fin |=> out_o.valid)
    else $error("find finished without a result");

  // Once a find is taken the block stops accepting transactions.
  a_find_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd == CmdFind) |=> !in_i.ready)
    else $error("transaction accepted during a find");

  // An empty-path error carries no pair, time or cells.
  a_empty_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.conflict_kind == KindEmpty) |->
      (out_o.second_robot == '0 && out_o.conflict_time == '0 &&
       out_o.from_x == '0 && out_o.to_y == '0))
    else $error("empty path result has stale fields");

  // The pair is always reported lower robot first.
  a_pair_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.conflict_kind == KindVertex || out_o.conflict_kind == KindEdge))
      |-> (out_o.first_robot < out_o.second_robot))
    else $error("conflict pair out of order");

endmodule

// ===== hw/rtl/mapcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path conflict finder controller
// Sequences the scan, cell load, vertex and edge phases of a find and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module mapcf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [mapcf_pkg::CmdW-1:0] in_cmd_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  mapcf_pkg::dp_sts_t      sts_i,
  output mapcf_pkg::dp_cmd_t      cmd_o
);
  import mapcf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    accept      = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          unique case (in_cmd_i)
            CmdClear:  cmd_o.clear  = 1'b1;
            CmdAppend: cmd_o.append = 1'b1;
            CmdFind: begin
              cmd_o.start = 1'b1;
              state_d     = StScan;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.err || sts_i.mk_zero) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end else begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.ld = 1'b1;
        if (sts_i.idx_last) state_d = StDrain;
      end
      StDrain: begin
        // The last read lands in the lookahead row during this cycle.
        cmd_o.idx_clr = 1'b1;
        state_d       = sts_i.init ? StAdv : StVertex;
      end
      StAdv: begin
        cmd_o.adv = 1'b1;
        state_d   = StLoad;
      end
      StVertex: begin
        cmd_o.vtx = 1'b1;
        if (sts_i.vtx_hit) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end else if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          if (sts_i.t_last) begin
            cmd_o.fin = 1'b1;
            state_d   = StIdle;
          end else begin
            state_d = StEdge;
          end
        end
      end
      StEdge: begin
        cmd_o.edge_chk = 1'b1;
        if (sts_i.edge_hit) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end else if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = StAdv;
        end
      end
      default: state_d = StIdle;
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.fin) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/mapcf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path conflict finder datapath
// Path memory, path lengths, the current and lookahead cell rows, the pair
// comparators and the result registers.
// ----------------------------------------------------------------------------
module mapcf_dp #(
  parameter int unsigned MAX_ROBOTS = 8,
  parameter int unsigned MAX_PATH   = 256,
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mapcf_pkg::dp_cmd_t            cmd_i,
  output mapcf_pkg::dp_sts_t            sts_o,
  input  logic [mapcf_pkg::RobotsCfgW-1:0] robots_in_use_i,
  input  logic                          cost_kind_i,
  input  logic [mapcf_pkg::RobotW-1:0]  robot_i,
  input  logic [mapcf_pkg::CoordW-1:0]  cell_x_i,
  input  logic [mapcf_pkg::CoordW-1:0]  cell_y_i,
  output logic [mapcf_pkg::KindW-1:0]   conflict_kind_o,
  output logic [mapcf_pkg::RobotW-1:0]  first_robot_o,
  output logic [mapcf_pkg::RobotW-1:0]  second_robot_o,
  output logic [mapcf_pkg::TimeW-1:0]   conflict_time_o,
  output logic [mapcf_pkg::CoordW-1:0]  from_x_o,
  output logic [mapcf_pkg::CoordW-1:0]  from_y_o,
  output logic [mapcf_pkg::CoordW-1:0]  to_x_o,
  output logic [mapcf_pkg::CoordW-1:0]  to_y_o,
  output logic [mapcf_pkg::CostW-1:0]   cost_value_o,
  output logic [mapcf_pkg::LongW-1:0]   longest_path_o,
  output logic [mapcf_pkg::CostW-1:0]   total_length_o,
  output logic                          overflowed_o
);
  import mapcf_pkg::*;

  localparam int unsigned RW    = $clog2(MAX_ROBOTS);
  localparam int unsigned NW    = $clog2(MAX_ROBOTS + 1);
  localparam int unsigned LW    = $clog2(MAX_PATH + 1);
  localparam int unsigned TW    = $clog2(MAX_ROBOTS * MAX_PATH + 1);
  localparam int unsigned AW    = $clog2(MAX_ROBOTS * MAX_PATH);
  localparam int unsigned CW    = 2 * COORD_BITS;
  localparam int unsigned Depth = MAX_ROBOTS * MAX_PATH;

  logic [CW-1:0] mem_q [Depth];
  logic [CW-1:0] rd_q;
  logic [CW-1:0] cur_q [MAX_ROBOTS];
  logic [CW-1:0] nxt_q [MAX_ROBOTS];

  logic [LW-1:0] len_q [MAX_ROBOTS];
  logic          ovf_q;
  logic [NW-1:0] n_q;
  logic [RW-1:0] idx_q;
  logic [LW-1:0] mk_q;
  logic [TW-1:0] tot_q;
  logic [LW-1:0] t_q;
  logic          init_q;
  logic          err_q;
  logic          cap_v_q;
  logic [RW-1:0] cap_r_q;

  kind_e         kind_q;
  logic [RW-1:0] ri_q, rj_q;
  logic [LW-1:0] ct_q;
  logic [CW-1:0] fc_q, tc_q;
  logic [CostW-1:0] res_cost_q;
  logic [LW-1:0] res_mk_q;
  logic [TW-1:0] res_tot_q;
  logic          res_ovf_q;

  logic          app_ok, app_full;
  logic [RW-1:0] app_r;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] wr_cell;
  logic [LW:0]   t1, lt;
  logic [LW:0]   lenm1;
  logic [LW-1:0] rd_t;
  logic [NW-1:0] n_clamp;
  logic [LW-1:0] len_i;
  logic          idx_lt_n;
  logic [CW-1:0] a_cell, b_cell;
  logic          vhit, ehit, i_ok;
  logic [RW-1:0] vj, ej;

  assign n_clamp = (32'(robots_in_use_i) > MAX_ROBOTS) ? NW'(MAX_ROBOTS)
                                                       : NW'(robots_in_use_i);
  assign app_ok   = 32'(robot_i) < MAX_ROBOTS;
  assign app_r    = RW'(robot_i);
  assign app_full = 32'(len_q[app_r]) >= MAX_PATH;
  assign wr_cell  = {COORD_BITS'(cell_y_i), COORD_BITS'(cell_x_i)};
  assign wr_addr  = AW'(AW'(app_r) * AW'(MAX_PATH) + AW'(len_q[app_r]));

  assign len_i    = len_q[idx_q];
  assign idx_lt_n = 32'(idx_q) < 32'(n_q);
  assign t1       = (LW + 1)'(t_q) + (LW + 1)'(1);
  assign lt       = init_q ? '0 : t1;
  assign lenm1    = (LW + 1)'(len_i) - (LW + 1)'(1);
  // Finished robots stay on their last cell.
  assign rd_t     = (lt < lenm1) ? LW'(lt) : LW'(lenm1);
  assign rd_addr  = AW'(AW'(idx_q) * AW'(MAX_PATH) + AW'(rd_t));

  assign a_cell = cur_q[idx_q];
  assign b_cell = nxt_q[idx_q];
  assign i_ok   = t1 < (LW + 1)'(len_i);

  always_comb begin
    vhit = 1'b0;
    vj   = '0;
    ehit = 1'b0;
    ej   = '0;
    for (int j = 0; j < MAX_ROBOTS; j++) begin
      if (!vhit && (32'(j) > 32'(idx_q)) && (32'(j) < 32'(n_q)) && (cur_q[j] == a_cell)) begin
        vhit = 1'b1;
        vj   = RW'(j);
      end
      if (!ehit && i_ok && (32'(j) > 32'(idx_q)) && (32'(j) < 32'(n_q)) &&
          (t1 < (LW + 1)'(len_q[j])) && (cur_q[j] == b_cell) && (nxt_q[j] == a_cell)) begin
        ehit = 1'b1;
        ej   = RW'(j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && app_ok && !app_full) mem_q[wr_addr] <= wr_cell;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cap_v_q) nxt_q[cap_r_q] <= rd_q;
    if (cmd_i.adv) begin
      for (int r = 0; r < MAX_ROBOTS; r++) cur_q[r] <= nxt_q[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_ROBOTS; r++) len_q[r] <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      idx_q      <= '0;
      mk_q       <= '0;
      tot_q      <= '0;
      t_q        <= '0;
      init_q     <= 1'b0;
      err_q      <= 1'b0;
      cap_v_q    <= 1'b0;
      cap_r_q    <= '0;
      kind_q     <= KindNone;
      ri_q       <= '0;
      rj_q       <= '0;
      ct_q       <= '0;
      fc_q       <= '0;
      tc_q       <= '0;
      res_cost_q <= '0;
      res_mk_q   <= '0;
      res_tot_q  <= '0;
      res_ovf_q  <= 1'b0;
    end else begin
      cap_v_q <= cmd_i.ld;
      cap_r_q <= idx_q;
      if (cmd_i.clear) begin
        for (int r = 0; r < MAX_ROBOTS; r++) len_q[r] <= '0;
        ovf_q <= 1'b0;
      end
      if (cmd_i.append && app_ok) begin
        if (app_full) ovf_q <= 1'b1;
        else len_q[app_r] <= len_q[app_r] + LW'(1);
      end
      if (cmd_i.start) begin
        n_q    <= n_clamp;
        idx_q  <= '0;
        mk_q   <= '0;
        tot_q  <= '0;
        t_q    <= '0;
        init_q <= 1'b1;
        err_q  <= 1'b0;
        kind_q <= KindNone;
        ri_q   <= '0;
        rj_q   <= '0;
        ct_q   <= '0;
        fc_q   <= '0;
        tc_q   <= '0;
      end
      if (cmd_i.scan && idx_lt_n) begin
        if (len_i > mk_q) mk_q <= len_i;
        tot_q <= tot_q + TW'(len_i);
        if (len_i == '0 && !err_q) begin
          err_q  <= 1'b1;
          kind_q <= KindEmpty;
          ri_q   <= idx_q;
        end
      end
      if (cmd_i.scan || cmd_i.ld) idx_q <= idx_q + RW'(1);
      if (cmd_i.adv) begin
        if (!init_q) t_q <= t_q + LW'(1);
        init_q <= 1'b0;
      end
      if (cmd_i.vtx) begin
        if (vhit) begin
          kind_q <= KindVertex;
          ri_q   <= idx_q;
          rj_q   <= vj;
          ct_q   <= t_q;
          fc_q   <= a_cell;
        end else begin
          idx_q <= idx_q + RW'(1);
        end
      end
      if (cmd_i.edge_chk) begin
        if (ehit) begin
          kind_q <= KindEdge;
          ri_q   <= idx_q;
          rj_q   <= ej;
          ct_q   <= t_q;
          fc_q   <= a_cell;
          tc_q   <= b_cell;
        end else begin
          idx_q <= idx_q + RW'(1);
        end
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      if (cmd_i.fin) begin
        res_cost_q <= cost_kind_i ? CostW'(tot_q) : CostW'(mk_q);
        res_mk_q   <= mk_q;
        res_tot_q  <= tot_q;
        res_ovf_q  <= ovf_q;
      end
    end
  end

  always_comb begin
    sts_o          = '0;
    sts_o.idx_last = (32'(idx_q) + 32'd1) >= 32'(n_q);
    sts_o.err      = err_q;
    sts_o.mk_zero  = (mk_q == '0);
    sts_o.init     = init_q;
    sts_o.vtx_hit  = vhit;
    sts_o.edge_hit = ehit;
    sts_o.t_last   = t1 >= (LW + 1)'(mk_q);
  end

  assign conflict_kind_o = kind_q;
  assign first_robot_o   = RobotW'(ri_q);
  assign second_robot_o  = RobotW'(rj_q);
  assign conflict_time_o = TimeW'(ct_q);
  assign from_x_o        = CoordW'(fc_q[COORD_BITS-1:0]);
  assign from_y_o        = CoordW'(fc_q[CW-1:COORD_BITS]);
  assign to_x_o          = CoordW'(tc_q[COORD_BITS-1:0]);
  assign to_y_o          = CoordW'(tc_q[CW-1:COORD_BITS]);
  assign cost_value_o    = res_cost_q;
  assign longest_path_o  = LongW'(res_mk_q);
  assign total_length_o  = CostW'(res_tot_q);
  assign overflowed_o    = res_ovf_q;

endmodule
